// ----- rtl/core/tld_pkg.sv -----
package tld_pkg;

  localparam logic [1:0] TGT_DATA = 2'd0;
  localparam logic [1:0] TGT_ECHO = 2'd1;
  localparam logic [1:0] TGT_INTR = 2'd2;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam logic [2:0] REG_CR_TO_NL  = 3'd0;
  localparam logic [2:0] REG_SIGNAL    = 3'd1;
  localparam logic [2:0] REG_CANONICAL = 3'd2;
  localparam logic [2:0] REG_ECHO      = 3'd3;
  localparam logic [2:0] REG_INTR_CHAR = 3'd4;
  localparam logic [2:0] REG_ERASE     = 3'd5;
  localparam logic [2:0] REG_EOF       = 3'd6;
  localparam logic [2:0] REG_FOREGND   = 3'd7;

  localparam logic [7:0] RST_INTR_CHAR  = 8'd3;
  localparam logic [7:0] RST_ERASE_CHAR = 8'd127;
  localparam logic [7:0] RST_EOF_CHAR   = 8'd4;

  typedef struct packed {
    logic [1:0] tgt;
    logic [7:0] data;
  } fix_item_t;

endpackage

// ----- rtl/core/tty_line_discipline_unit.sv -----
// an accepted item is latched, then decoded; its results go out through S_FIX and the output register
// echo, interrupt and raw items: one result per cycle while the output register is free
// line commit: any newline echo comes first, then the stored line is read out through S_DRD and S_DWR
// in_tready is high only while the sequencer is idle; one item at a time
// reset (rst_n, synchronous): registers to defaults, line emptied, output register empty
module tty_line_discipline_unit #(
  parameter int LINE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] target
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tld_pkg::*;

  localparam int LEN_W = $clog2(LINE_DEPTH + 1);
  localparam int AW    = $clog2(LINE_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_L    = LEN_W'(LINE_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_M1_L = LEN_W'(LINE_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FIX    = 3'd2;
  localparam logic [2:0] S_DRD    = 3'd3;
  localparam logic [2:0] S_DWR    = 3'd4;

  // configuration
  logic       cr_en_r, sig_en_r, canon_en_r, echo_en_r, fg_r;
  logic [7:0] intr_char_r, erase_char_r, eof_char_r;
  logic       cfg_we;

  // sequencer
  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] didx_r, didx_nxt;
  logic [1:0]       fix_idx_r, fix_idx_nxt;
  logic [1:0]       fix_cnt_r, fix_cnt_nxt;
  logic             drain_r, drain_nxt;
  logic [7:0]       c_r, c_nxt;
  fix_item_t        fix_r [3];
  fix_item_t        fix_nxt [3];

  // decode of the latched byte
  fix_item_t        dec_fix [3];
  logic [1:0]       dec_cnt;
  logic             dec_drain;
  logic             dec_we;
  logic [LEN_W-1:0] dec_len;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic [1:0] out_tgt_r, out_tgt_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_free;

  // line store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  tld_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_en_r      <= 1'b1;
      sig_en_r     <= 1'b1;
      canon_en_r   <= 1'b1;
      echo_en_r    <= 1'b1;
      intr_char_r  <= RST_INTR_CHAR;
      erase_char_r <= RST_ERASE_CHAR;
      eof_char_r   <= RST_EOF_CHAR;
      fg_r         <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_CR_TO_NL:  cr_en_r      <= pwdata[0];
        REG_SIGNAL:    sig_en_r     <= pwdata[0];
        REG_CANONICAL: canon_en_r   <= pwdata[0];
        REG_ECHO:      echo_en_r    <= pwdata[0];
        REG_INTR_CHAR: intr_char_r  <= pwdata[7:0];
        REG_ERASE:     erase_char_r <= pwdata[7:0];
        REG_EOF:       eof_char_r   <= pwdata[7:0];
        REG_FOREGND:   fg_r         <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CR_TO_NL:  prdata = {31'd0, cr_en_r};
      REG_SIGNAL:    prdata = {31'd0, sig_en_r};
      REG_CANONICAL: prdata = {31'd0, canon_en_r};
      REG_ECHO:      prdata = {31'd0, echo_en_r};
      REG_INTR_CHAR: prdata = {24'd0, intr_char_r};
      REG_ERASE:     prdata = {24'd0, erase_char_r};
      REG_EOF:       prdata = {24'd0, eof_char_r};
      REG_FOREGND:   prdata = {31'd0, fg_r};
      default:       prdata = 32'd0;
    endcase
  end

  // classify the latched byte into a short fixed result list plus an optional line drain
  always_comb begin
    dec_fix[0] = '{tgt: TGT_ECHO, data: c_r};
    dec_fix[1] = '{tgt: TGT_ECHO, data: c_r};
    dec_fix[2] = '{tgt: TGT_ECHO, data: c_r};
    dec_cnt    = 2'd0;
    dec_drain  = 1'b0;
    dec_we     = 1'b0;
    dec_len    = len_r;
    if (sig_en_r && c_r == intr_char_r) begin
      dec_fix[0] = '{tgt: TGT_INTR, data: 8'd0};
      dec_cnt    = fg_r ? 2'd1 : 2'd0;
    end else if (canon_en_r) begin
      if (c_r == erase_char_r || c_r == CH_BS) begin
        if (len_r != '0) begin
          dec_len    = len_r - 1'b1;
          dec_fix[0] = '{tgt: TGT_ECHO, data: CH_BS};
          dec_fix[1] = '{tgt: TGT_ECHO, data: CH_SP};
          dec_fix[2] = '{tgt: TGT_ECHO, data: CH_BS};
          dec_cnt    = echo_en_r ? 2'd3 : 2'd0;
        end
      end else if (c_r == eof_char_r) begin
        dec_drain = (len_r != '0);
      end else if (c_r == CH_NL) begin
        if (len_r < DEPTH_L) begin
          dec_we  = 1'b1;
          dec_len = len_r + 1'b1;
        end
        dec_fix[0] = '{tgt: TGT_ECHO, data: CH_CR};
        dec_fix[1] = '{tgt: TGT_ECHO, data: CH_NL};
        dec_cnt    = echo_en_r ? 2'd2 : 2'd0;
        dec_drain  = 1'b1;
      end else if (len_r < DEPTH_M1_L) begin
        dec_we  = 1'b1;
        dec_len = len_r + 1'b1;
        dec_cnt = echo_en_r ? 2'd1 : 2'd0;
      end
    end else begin
      dec_fix[0] = '{tgt: TGT_DATA, data: c_r};
      if (c_r == CH_NL) begin
        dec_fix[1] = '{tgt: TGT_ECHO, data: CH_CR};
        dec_fix[2] = '{tgt: TGT_ECHO, data: CH_NL};
        dec_cnt    = echo_en_r ? 2'd3 : 2'd1;
      end else begin
        dec_cnt = echo_en_r ? 2'd2 : 2'd1;
      end
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    didx_nxt      = didx_r;
    fix_idx_nxt   = fix_idx_r;
    fix_cnt_nxt   = fix_cnt_r;
    drain_nxt     = drain_r;
    c_nxt         = c_r;
    fix_nxt       = fix_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_tgt_nxt   = out_tgt_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = len_r[AW-1:0];
    ram_wdata     = c_r;
    ram_re        = 1'b0;
    ram_raddr     = didx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          c_nxt     = (in_tdata == CH_CR && cr_en_r) ? CH_NL : in_tdata;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ram_we      = dec_we;
        len_nxt     = dec_len;
        fix_nxt     = dec_fix;
        fix_cnt_nxt = dec_cnt;
        fix_idx_nxt = 2'd0;
        drain_nxt   = dec_drain;
        didx_nxt    = '0;
        if (dec_cnt != 2'd0) begin
          state_nxt = S_FIX;
        end else if (dec_drain) begin
          state_nxt = S_DRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = fix_r[fix_idx_r].data;
          out_tgt_nxt   = fix_r[fix_idx_r].tgt;
          out_last_nxt  = (fix_idx_r == fix_cnt_r - 2'd1) && !drain_r;
          if (fix_idx_r == fix_cnt_r - 2'd1) begin
            state_nxt = drain_r ? S_DRD : S_IDLE;
          end else begin
            fix_idx_nxt = fix_idx_r + 2'd1;
          end
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        state_nxt = S_DWR;
      end
      S_DWR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_tgt_nxt   = TGT_DATA;
          out_last_nxt  = (didx_r + 1'b1 == len_r);
          if (didx_r + 1'b1 == len_r) begin
            len_nxt   = '0;
            didx_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            didx_nxt  = didx_r + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = didx_nxt[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      didx_r      <= '0;
      fix_idx_r   <= 2'd0;
      fix_cnt_r   <= 2'd0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      didx_r      <= didx_nxt;
      fix_idx_r   <= fix_idx_nxt;
      fix_cnt_r   <= fix_cnt_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    fix_r      <= fix_nxt;
    out_data_r <= out_data_nxt;
    out_tgt_r  <= out_tgt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_tgt_r;
  assign out_tlast  = out_last_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= DEPTH_L)
    else $error("line length above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while decoding");

  a_drain_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRD || state_r == S_DWR) |-> (didx_r < len_r))
    else $error("drain index past line length");

  a_fix_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |-> (fix_idx_r < fix_cnt_r))
    else $error("fixed result index out of range");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DWR && out_free && out_last_nxt) |=> (len_r == '0 && state_r == S_IDLE))
    else $error("line not cleared after commit");

endmodule

// ----- rtl/core/tld_ram.sv -----
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sim/tb_tty_line_discipline_unit.sv -----
`timescale 1ns / 100ps

module tb_tty_line_discipline_unit;
  import tld_pkg::*;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [1:0] tgt;
    logic [7:0] data;
    logic       last_flag;
  } tty_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  tty_line_discipline_unit #(.LINE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // mirror of the register file
  logic       map_cr, sig_en, canon_en, echo_en, fg_present;
  logic [7:0] intr_ch, erase_ch, eof_ch;

  // predicted line editor state
  logic [7:0] line_buf [DEPTH];
  int         pend_len = 0;

  logic [7:0]  keystroke_q[$];
  tty_result_t tty_out_q[$];

  int   keys_pushed = 0;
  int   keys_taken = 0;
  int   errors = 0;
  int   stall_cycles = 0;
  int   hold_at = 120;
  bit   idle_on = 1'b1;
  logic in_taken = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void expect_out(input logic [1:0] tgt, input logic [7:0] b);
    tty_result_t r;
    r.tgt = tgt;
    r.data = b;
    r.last_flag = 1'b0;
    tty_out_q.push_back(r);
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < pend_len; i++) expect_out(TGT_DATA, line_buf[i]);
    pend_len = 0;
  endfunction

  function automatic void predict_key(input logic [7:0] key);
    logic [7:0]  c;
    int          n;
    tty_result_t r;
    n = tty_out_q.size();
    c = key;
    if (c == CH_CR && map_cr) c = CH_NL;
    if (sig_en && c == intr_ch) begin
      if (fg_present) expect_out(TGT_INTR, 8'h00);
    end else if (canon_en) begin
      if (c == erase_ch || c == CH_BS) begin
        if (pend_len > 0) begin
          pend_len--;
          if (echo_en) begin
            expect_out(TGT_ECHO, CH_BS);
            expect_out(TGT_ECHO, CH_SP);
            expect_out(TGT_ECHO, CH_BS);
          end
        end
      end else if (c == eof_ch) begin
        flush_line();
      end else if (c == CH_NL) begin
        if (pend_len < DEPTH) begin
          line_buf[pend_len] = CH_NL;
          pend_len++;
        end
        if (echo_en) begin
          expect_out(TGT_ECHO, CH_CR);
          expect_out(TGT_ECHO, CH_NL);
        end
        flush_line();
      end else if (pend_len < DEPTH - 1) begin
        line_buf[pend_len] = c;
        pend_len++;
        if (echo_en) expect_out(TGT_ECHO, c);
      end
    end else begin
      expect_out(TGT_DATA, c);
      if (echo_en) begin
        if (c == CH_NL) begin
          expect_out(TGT_ECHO, CH_CR);
          expect_out(TGT_ECHO, CH_NL);
        end else begin
          expect_out(TGT_ECHO, c);
        end
      end
    end
    if (tty_out_q.size() > n) begin
      r = tty_out_q.pop_back();
      r.last_flag = 1'b1;
      tty_out_q.push_back(r);
    end
  endfunction

  // key driver
  int gap_left = 0;
  always @(negedge clk) begin
    if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      gap_left <= $urandom_range(0, 2);
    end else if (keystroke_q.size() > 0) begin
      in_tdata <= keystroke_q.pop_front();
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result receiver with one long hold-off
  int  hold_left = 0;
  int  rcv_gap = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && keys_taken >= hold_at) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (rcv_gap > 0) begin
      out_tready <= 1'b0;
      rcv_gap <= rcv_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rcv_gap <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin : monitor
    tty_result_t want;
    logic        in_fire, out_fire, cfg_fire;
    in_fire = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    cfg_fire = psel && penable && pwrite && pready;
    in_taken <= in_fire;
    if (rst_n) begin
      if (in_fire) begin
        predict_key(in_tdata);
        keys_taken++;
      end
      if (out_fire) begin
        if (tty_out_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual tgt=%0d byte=%02h last=%0b",
                   $time, out_tuser, out_tdata, out_tlast);
          errors++;
        end else begin
          want = tty_out_q.pop_front();
          if (out_tuser !== want.tgt || out_tdata !== want.data ||
              out_tlast !== want.last_flag) begin
            $display("%0t: expected tgt=%0d byte=%02h last=%0b, actual tgt=%0d byte=%02h last=%0b",
                     $time, want.tgt, want.data, want.last_flag,
                     out_tuser, out_tdata, out_tlast);
            errors++;
          end
        end
      end
      if (in_fire || out_fire || cfg_fire) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CR_TO_NL:  map_cr = val[0];
      REG_SIGNAL:    sig_en = val[0];
      REG_CANONICAL: canon_en = val[0];
      REG_ECHO:      echo_en = val[0];
      REG_INTR_CHAR: intr_ch = val;
      REG_ERASE:     erase_ch = val;
      REG_EOF:       eof_ch = val;
      REG_FOREGND:   fg_present = val[0];
      default: ;
    endcase
  endtask

  task automatic set_modes(input logic cr, input logic sig, input logic can, input logic ech,
                           input logic [7:0] ic, input logic [7:0] ec, input logic [7:0] fc,
                           input logic fg);
    write_reg(REG_CR_TO_NL, {7'd0, cr});
    write_reg(REG_SIGNAL, {7'd0, sig});
    write_reg(REG_CANONICAL, {7'd0, can});
    write_reg(REG_ECHO, {7'd0, ech});
    write_reg(REG_INTR_CHAR, ic);
    write_reg(REG_ERASE, ec);
    write_reg(REG_EOF, fc);
    write_reg(REG_FOREGND, {7'd0, fg});
  endtask

  // wait until every key is taken and every result has come out
  task automatic drain_out();
    while (keys_taken != keys_pushed || tty_out_q.size() != 0) @(negedge clk);
  endtask

  function automatic void push_key(input logic [7:0] k);
    keystroke_q.push_back(k);
    keys_pushed++;
  endfunction

  function automatic logic [7:0] pick_char(input logic [7:0] dflt);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return dflt;
  endfunction

  // one edited line with random content, or a stray key
  function automatic void gen_line();
    int len;
    int sel;
    if ($urandom_range(0, 5) == 0) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) push_key(intr_ch);
      else push_key(8'($urandom_range(0, 255)));
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 34) : $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) push_key($urandom_range(0, 1) ? erase_ch : CH_BS);
      else if (sel == 1) push_key(8'($urandom_range(0, 255)));
      else push_key(8'($urandom_range(32, 126)));
    end
    sel = $urandom_range(0, 7);
    case (sel)
      0: push_key(eof_ch);
      1: push_key(CH_CR);
      2: push_key(intr_ch);
      default: push_key(CH_NL);
    endcase
  endfunction

  initial begin
    int base;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // canonical editing with echo and a foreground group
    set_modes(1'b1, 1'b1, 1'b1, 1'b1, RST_INTR_CHAR, RST_ERASE_CHAR, RST_EOF_CHAR, 1'b1);
    push_key(8'h61);
    push_key(8'h00);
    push_key(8'hFF);
    push_key(RST_ERASE_CHAR);
    push_key(CH_BS);
    push_key(CH_BS);
    push_key(CH_BS);
    push_key(RST_INTR_CHAR);
    push_key(RST_EOF_CHAR);
    push_key(8'h41);
    push_key(RST_EOF_CHAR);
    push_key(8'h42);
    push_key(CH_CR);
    push_key(CH_NL);
    drain_out();
    repeat (12) @(negedge clk);

    // echo off, no foreground group
    set_modes(1'b1, 1'b1, 1'b1, 1'b0, RST_INTR_CHAR, RST_ERASE_CHAR, RST_EOF_CHAR, 1'b0);
    push_key(RST_INTR_CHAR);
    push_key(8'h78);
    push_key(RST_ERASE_CHAR);
    push_key(RST_EOF_CHAR);
    push_key(8'h79);
    push_key(CH_NL);
    drain_out();
    repeat (12) @(negedge clk);

    // raw forwarding
    set_modes(1'b1, 1'b1, 1'b0, 1'b1, RST_INTR_CHAR, RST_ERASE_CHAR, RST_EOF_CHAR, 1'b1);
    push_key(CH_CR);
    push_key(CH_NL);
    push_key(8'hFF);
    push_key(8'h00);
    push_key(RST_INTR_CHAR);
    drain_out();
    repeat (12) @(negedge clk);
    write_reg(REG_CR_TO_NL, 8'h00);
    push_key(CH_CR);

    for (int ph = 0; ph < 12; ph++) begin
      drain_out();
      repeat (12) @(negedge clk);
      if (ph >= 10) idle_on = 1'b0;
      case (ph)
        0: set_modes(1'b1, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
        1: set_modes(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        2: set_modes(1'b1, 1'b1, 1'b0, 1'b1, RST_INTR_CHAR, RST_ERASE_CHAR, RST_EOF_CHAR,
                     1'b1);
        11: set_modes(1'b1, 1'b1, 1'b1, 1'b1, RST_INTR_CHAR, RST_ERASE_CHAR, RST_EOF_CHAR,
                      1'b1);
        default: set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                           pick_char(RST_INTR_CHAR), pick_char(RST_ERASE_CHAR),
                           pick_char(RST_EOF_CHAR), 1'($urandom_range(0, 1)));
      endcase
      base = keys_pushed;
      while (keys_pushed - base < 31) gen_line();
    end

    drain_out();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tld_pkg.sv
rtl/core/tld_ram.sv
rtl/core/tty_line_discipline_unit.sv
sim/tb_tty_line_discipline_unit.sv
